[design/abpf_pkg.sv]
// Shared types, register indexes and pixel format codes for the alpha blend block.
// Used by the top level, abpf_cfg and abpf_blend; depends on nothing.
package abpf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned DimW     = 14;

  localparam logic [CfgIdxW-1:0] REG_SURFACE_READY  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PIXEL_FORMAT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WIDE_PIXELS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SURFACE_WIDTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SURFACE_HEIGHT = 3'd4;

  localparam logic [1:0] FMT_RGBX8888 = 2'd0;
  localparam logic [1:0] FMT_BGRX8888 = 2'd1;
  localparam logic [1:0] FMT_RGB565   = 2'd2;
  localparam logic [1:0] FMT_INDEXED  = 2'd3;

  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic            surface_ready;
    logic [1:0]      pixel_format;
    logic            wide_pixels;
    logic [DimW-1:0] surface_width;
    logic [DimW-1:0] surface_height;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [23:0]        source_color;
    logic [7:0]         alpha;
    logic [31:0]        dest_pixel;
  } pix_req_t;

  typedef struct packed {
    logic [31:0] new_pixel;
    logic        write_enable;
  } pix_res_t;

  // (s*a + d*(255-a) + 127) / 255, with the divide done as add and shift
  function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [7:0] a);
    logic [16:0] sum;
    logic [16:0] q;
    begin
      sum = 17'({8'h00, s} * {8'h00, a}) +
            17'({8'h00, d} * {8'h00, ALPHA_OPAQUE - a}) + 17'd127;
      q   = (sum + 17'd1 + (sum >> 8)) >> 8;
      mix = q[7:0];
    end
  endfunction

endpackage

[design/alpha_blend_pixel_formats_top.sv]
// Top level of the alpha blend block: request register, blend datapath, result register.
// Depends on abpf_pkg, abpf_cfg and abpf_blend.
//
// One pixel request per clock is accepted while in_stall is low; a request is registered,
// blended by one pass of combinational logic (six 8x8 multiplies and an add-and-shift divide
// by 255 per channel) and registered again before it appears as a result. With the result
// side stalled, one more request is held in the input register before in_stall rises. Every
// request gives exactly one result. Configuration writes are registered and should be
// issued only while no request is in flight.
module alpha_blend_pixel_formats_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_pixel_x,
  input  logic signed [15:0]            in_pixel_y,
  input  logic [23:0]                   in_source_color,
  input  logic [7:0]                    in_alpha,
  input  logic [31:0]                   in_dest_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_new_pixel,
  output logic                          out_write_enable,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [abpf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [abpf_pkg::CfgDataW-1:0] cfg_data
);

  abpf_pkg::cfg_t     cfg;
  abpf_pkg::pix_req_t req_r;
  abpf_pkg::pix_res_t res;
  abpf_pkg::pix_res_t res_r;
  logic               req_valid_r, req_valid_nxt;
  logic               out_valid_r;
  logic               advance;
  logic               in_take;

  abpf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  abpf_blend u_blend (
    .cfg (cfg),
    .req (req_r),
    .res (res)
  );

  assign advance       = !out_valid_r || !out_stall;
  assign in_stall      = req_valid_r && !advance;
  assign in_take       = in_valid && !in_stall;
  assign req_valid_nxt = in_take || (req_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      if (advance) begin
        out_valid_r <= req_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.pixel_x      <= in_pixel_x;
      req_r.pixel_y      <= in_pixel_y;
      req_r.source_color <= in_source_color;
      req_r.alpha        <= in_alpha;
      req_r.dest_pixel   <= in_dest_pixel;
    end
    if (advance && req_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_pixel    = res_r.new_pixel;
  assign out_write_enable = res_r.write_enable;

endmodule

[design/abpf_cfg.sv]
// Configuration register file for the alpha blend block.
// Depends on abpf_pkg for register indexes and the cfg_t layout.
module abpf_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [abpf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [abpf_pkg::CfgDataW-1:0] cfg_data,
  output abpf_pkg::cfg_t                cfg
);

  abpf_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surface_ready  <= 1'b0;
      cfg_r.pixel_format   <= abpf_pkg::FMT_RGBX8888;
      cfg_r.wide_pixels    <= 1'b1;
      cfg_r.surface_width  <= '0;
      cfg_r.surface_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        abpf_pkg::REG_SURFACE_READY:  cfg_r.surface_ready  <= cfg_data[0];
        abpf_pkg::REG_PIXEL_FORMAT:   cfg_r.pixel_format   <= cfg_data[1:0];
        abpf_pkg::REG_WIDE_PIXELS:    cfg_r.wide_pixels    <= cfg_data[0];
        abpf_pkg::REG_SURFACE_WIDTH:  cfg_r.surface_width  <= cfg_data[abpf_pkg::DimW-1:0];
        abpf_pkg::REG_SURFACE_HEIGHT: cfg_r.surface_height <= cfg_data[abpf_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/abpf_blend.sv]
// Blend datapath: clipping, native conversion and per-channel source-over mix.
// Purely combinational; depends on abpf_pkg for types, codes and mix().
module abpf_blend (
  input  abpf_pkg::cfg_t     cfg,
  input  abpf_pkg::pix_req_t req,
  output abpf_pkg::pix_res_t res
);

  logic [7:0]  sr, sg, sb;
  logic [7:0]  hi, mid, lo;
  logic [7:0]  dr, dg, db;
  logic [7:0]  mr, mg, mb;
  logic        inside_x, inside_y, suppress;
  logic [31:0] native;
  logic [31:0] blended;
  logic [31:0] nv;

  assign sr  = req.source_color[23:16];
  assign sg  = req.source_color[15:8];
  assign sb  = req.source_color[7:0];
  assign hi  = req.dest_pixel[23:16];
  assign mid = req.dest_pixel[15:8];
  assign lo  = req.dest_pixel[7:0];
  assign dr  = {req.dest_pixel[15:11], 3'b000};
  assign dg  = {req.dest_pixel[10:5], 2'b00};
  assign db  = {req.dest_pixel[4:0], 3'b000};

  assign inside_x = !req.pixel_x[15] &&
                    (req.pixel_x[15:0] < {2'b00, cfg.surface_width});
  assign inside_y = !req.pixel_y[15] &&
                    (req.pixel_y[15:0] < {2'b00, cfg.surface_height});
  assign suppress = !cfg.surface_ready || (req.alpha == abpf_pkg::ALPHA_CLEAR) ||
                    !inside_x || !inside_y;

  always_comb begin
    unique case (cfg.pixel_format)
      abpf_pkg::FMT_RGBX8888: native = {8'h00, sr, sg, sb};
      abpf_pkg::FMT_BGRX8888: native = {8'h00, sb, sg, sr};
      abpf_pkg::FMT_RGB565:   native = {16'h0000, sr[7:3], sg[7:2], sb[7:3]};
      abpf_pkg::FMT_INDEXED:  native = {8'h00, req.source_color};
      default:                native = {8'h00, req.source_color};
    endcase
  end

  always_comb begin
    if (!cfg.wide_pixels) begin
      mr = abpf_pkg::mix(sr, dr, req.alpha);
      mg = abpf_pkg::mix(sg, dg, req.alpha);
      mb = abpf_pkg::mix(sb, db, req.alpha);
      blended = {16'h0000, mr[7:3], mg[7:2], mb[7:3]};
    end else if (cfg.pixel_format == abpf_pkg::FMT_RGBX8888) begin
      mr = abpf_pkg::mix(sr, hi, req.alpha);
      mg = abpf_pkg::mix(sg, mid, req.alpha);
      mb = abpf_pkg::mix(sb, lo, req.alpha);
      blended = {8'h00, mr, mg, mb};
    end else begin
      mr = abpf_pkg::mix(sr, lo, req.alpha);
      mg = abpf_pkg::mix(sg, mid, req.alpha);
      mb = abpf_pkg::mix(sb, hi, req.alpha);
      blended = {8'h00, mb, mg, mr};
    end
  end

  always_comb begin
    nv = (req.alpha == abpf_pkg::ALPHA_OPAQUE) ? native : blended;
    if (!cfg.wide_pixels) begin
      nv = {16'h0000, nv[15:0]};
    end
    if (suppress) begin
      res.new_pixel    = req.dest_pixel;
      res.write_enable = 1'b0;
    end else begin
      res.new_pixel    = nv;
      res.write_enable = 1'b1;
    end
  end

endmodule

[design/abpf_checker.sv]
// Port-level checks for the alpha blend top level, and the bind that attaches them.
// Depends on alpha_blend_pixel_formats_top port names only.
module abpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_new_pixel,
  input logic        out_write_enable
);

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) in_stall |-> (out_valid && out_stall))
    else $error("request stalled while result side is free");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_new_pixel) &&
                                  $stable(out_write_enable)))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> ##1 out_valid)
    else $error("request lost on empty result side");

endmodule

bind alpha_blend_pixel_formats_top abpf_checker u_abpf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_new_pixel    (out_new_pixel),
  .out_write_enable (out_write_enable)
);

[dv/alpha_blend_pixel_formats_top_test.sv]
// Self-checking testbench for alpha_blend_pixel_formats_top: drives pixel requests and
// register writes, predicts each blended pixel and compares it with the result stream.
// Depends on abpf_pkg and the design folder.
module alpha_blend_pixel_formats_top_test;
  import abpf_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_AFTER      = 240;
  localparam int HOLD_CYCLES     = 200;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int PRINT_CAP       = 40;

  class pixel_checker;
    cfg_t     cfg;
    pix_res_t expected_pixels[$];
    int       n_accepted;
    int       n_checked;
    int       n_written;
    int       n_errors;

    function new();
      cfg = '0;
      cfg.wide_pixels = 1'b1;
    endfunction

    function int unsigned blend_channel(int unsigned s, int unsigned d, int unsigned a);
      return (s * a + d * (255 - a) + 127) / 255;
    endfunction

    function logic [31:0] native_color(logic [23:0] color);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = color[23:16];
      g = color[15:8];
      b = color[7:0];
      case (cfg.pixel_format)
        FMT_RGBX8888: return {8'h00, r, g, b};
        FMT_BGRX8888: return {8'h00, b, g, r};
        FMT_RGB565:   return {16'h0000, r[7:3], g[7:2], b[7:3]};
        default:      return {8'h00, color};
      endcase
    endfunction

    function pix_res_t blend_pixel(pix_req_t req);
      pix_res_t    res;
      int          xi;
      int          yi;
      logic [7:0]  src_r;
      logic [7:0]  src_g;
      logic [7:0]  src_b;
      logic [7:0]  hi;
      logic [7:0]  mid;
      logic [7:0]  lo;
      logic [7:0]  mr;
      logic [7:0]  mg;
      logic [7:0]  mb;
      logic [31:0] nv;
      xi    = req.pixel_x;
      yi    = req.pixel_y;
      src_r = req.source_color[23:16];
      src_g = req.source_color[15:8];
      src_b = req.source_color[7:0];
      if (!cfg.surface_ready || req.alpha == ALPHA_CLEAR || xi < 0 || yi < 0 ||
          xi >= int'(cfg.surface_width) || yi >= int'(cfg.surface_height)) begin
        res.new_pixel    = req.dest_pixel;
        res.write_enable = 1'b0;
        return res;
      end
      if (req.alpha == ALPHA_OPAQUE) begin
        nv = native_color(req.source_color);
      end else if (cfg.wide_pixels) begin
        hi  = req.dest_pixel[23:16];
        mid = req.dest_pixel[15:8];
        lo  = req.dest_pixel[7:0];
        if (cfg.pixel_format == FMT_RGBX8888) begin
          mr = 8'(blend_channel(src_r, hi, req.alpha));
          mg = 8'(blend_channel(src_g, mid, req.alpha));
          mb = 8'(blend_channel(src_b, lo, req.alpha));
          nv = {8'h00, mr, mg, mb};
        end else begin
          mb = 8'(blend_channel(src_b, hi, req.alpha));
          mg = 8'(blend_channel(src_g, mid, req.alpha));
          mr = 8'(blend_channel(src_r, lo, req.alpha));
          nv = {8'h00, mb, mg, mr};
        end
      end else begin
        mr = 8'(blend_channel(src_r, {req.dest_pixel[15:11], 3'b000}, req.alpha));
        mg = 8'(blend_channel(src_g, {req.dest_pixel[10:5], 2'b00}, req.alpha));
        mb = 8'(blend_channel(src_b, {req.dest_pixel[4:0], 3'b000}, req.alpha));
        nv = {16'h0000, mr[7:3], mg[7:2], mb[7:3]};
      end
      if (!cfg.wide_pixels) begin
        nv[31:16] = 16'h0000;
      end
      res.new_pixel    = nv;
      res.write_enable = 1'b1;
      return res;
    endfunction

    function void note_request(pix_req_t req);
      expected_pixels.push_back(blend_pixel(req));
      n_accepted++;
    endfunction

    task report(string msg);
      if (n_errors < PRINT_CAP) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      n_errors++;
    endtask

    task check_result(logic [31:0] px, logic we);
      pix_res_t exp_res;
      n_checked++;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %0d with no request pending: pixel %h enable %b",
                         n_checked, px, we));
        return;
      end
      exp_res = expected_pixels.pop_front();
      if (px !== exp_res.new_pixel) begin
        report($sformatf("result %0d new_pixel %h, predicted %h",
                         n_checked, px, exp_res.new_pixel));
      end
      if (we !== exp_res.write_enable) begin
        report($sformatf("result %0d write_enable %b, predicted %b",
                         n_checked, we, exp_res.write_enable));
      end
      if (exp_res.write_enable) begin
        n_written++;
      end
    endtask
  endclass

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic signed [15:0]  in_pixel_x       = '0;
  logic signed [15:0]  in_pixel_y       = '0;
  logic [23:0]         in_source_color  = '0;
  logic [7:0]          in_alpha         = '0;
  logic [31:0]         in_dest_pixel    = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [31:0]         out_new_pixel;
  logic                out_write_enable;
  logic                cfg_valid        = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index        = '0;
  logic [CfgDataW-1:0] cfg_data         = '0;
  logic                hold_off         = 1'b0;
  int                  cycles           = 0;
  int                  calm_left        = 0;
  int                  n_settings       = 0;

  pixel_checker blend_check = new();

  alpha_blend_pixel_formats_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_source_color  (in_source_color),
    .in_alpha         (in_alpha),
    .in_dest_pixel    (in_dest_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_pixel    (out_new_pixel),
    .out_write_enable (out_write_enable),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) calm_left = $urandom_range(10, 30);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return 1;
    if (r < 30) return 8192;
    if (r < 70) return $urandom_range(2, 64);
    return $urandom_range(0, 8192);
  endfunction

  function automatic int pick_coord(int dim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, dim + 1);
    if (r < 75) return dim - int'($urandom_range(0, 1));
    if (r < 85) return -int'($urandom_range(1, 4));
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int pick_alpha();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return ALPHA_CLEAR;
    if (r < 25) return ALPHA_OPAQUE;
    if (r < 30) return ($urandom_range(0, 1) != 0) ? 1 : 254;
    return $urandom_range(0, 255);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CfgDataW-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SURFACE_READY:  blend_check.cfg.surface_ready  = val[0];
      REG_PIXEL_FORMAT:   blend_check.cfg.pixel_format   = val[1:0];
      REG_WIDE_PIXELS:    blend_check.cfg.wide_pixels    = val[0];
      REG_SURFACE_WIDTH:  blend_check.cfg.surface_width  = val[DimW-1:0];
      REG_SURFACE_HEIGHT: blend_check.cfg.surface_height = val[DimW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int ready, input int fmt, input int wide,
                               input int w, input int h);
    write_reg(REG_SURFACE_READY, ready);
    write_reg(REG_PIXEL_FORMAT, fmt);
    write_reg(REG_WIDE_PIXELS, wide);
    write_reg(REG_SURFACE_WIDTH, w);
    write_reg(REG_SURFACE_HEIGHT, h);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic send_pixel(input int x, input int y, input logic [23:0] color,
                            input int alpha, input logic [31:0] dest);
    pix_req_t req;
    int       gap;
    req.pixel_x      = 16'(x);
    req.pixel_y      = 16'(y);
    req.source_color = color;
    req.alpha        = 8'(alpha);
    req.dest_pixel   = dest;
    in_valid        <= 1'b1;
    in_pixel_x      <= req.pixel_x;
    in_pixel_y      <= req.pixel_y;
    in_source_color <= req.source_color;
    in_alpha        <= req.alpha;
    in_dest_pixel   <= req.dest_pixel;
    do @(posedge clk); while (in_stall);
    blend_check.note_request(req);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (blend_check.expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic random_pixels(input int n);
    int x;
    int y;
    for (int i = 0; i < n; i++) begin
      x = pick_coord(blend_check.cfg.surface_width);
      y = pick_coord(blend_check.cfg.surface_height);
      send_pixel(x, y, 24'($urandom()), pick_alpha(), $urandom());
    end
  endtask

  initial begin
    int stall_left;
    int quiet_left;
    int r;
    stall_left = 0;
    quiet_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        blend_check.check_result(out_new_pixel, out_write_enable);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (quiet_left > 0) begin
        quiet_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) quiet_left = $urandom_range(20, 80);
        else if (r < 30) stall_left = $urandom_range(1, 3);
        else if (r < 33) stall_left = $urandom_range(10, 40);
      end
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  // hold the result side off while requests keep coming, so the input backs up
  initial begin
    while (blend_check.n_accepted < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_pixel(5, 5, 24'h123456, 128, 32'hDEADBEEF);
    send_pixel(0, 0, 24'hFFFFFF, 255, 32'h00000000);
    drain();

    apply_setting(1, FMT_RGBX8888, 1, 8192, 8192);
    send_pixel(-32768, 0, 24'h80FF01, 128, 32'h00112233);
    send_pixel(32767, -32768, 24'h55AA55, 200, 32'hA5A5A5A5);
    send_pixel(8191, 8191, 24'hFFFFFF, 255, 32'hFFFFFFFF);
    send_pixel(8192, 0, 24'h0F0F0F, 255, 32'h12345678);
    send_pixel(0, 8192, 24'h345678, 100, 32'h87654321);
    send_pixel(5, 32767, 24'h345678, 100, 32'h87654321);
    send_pixel(10, 20, 24'h000000, 0, 32'hFFFFFFFF);
    send_pixel(100, 8191, 24'h000000, 1, 32'hFFFFFFFF);
    send_pixel(8191, 0, 24'hFFFFFF, 254, 32'h00000000);
    drain();

    apply_setting(1, FMT_BGRX8888, 1, 1, 1);
    send_pixel(0, 0, 24'h102030, 255, 32'hFF000000);
    send_pixel(0, 0, 24'hC08040, 100, 32'hFF123456);
    send_pixel(1, 0, 24'hC08040, 100, 32'hFF123456);
    drain();

    apply_setting(1, FMT_RGB565, 0, 640, 480);
    send_pixel(639, 479, 24'hFFFFFF, 255, 32'hFFFF0000);
    send_pixel(320, 240, 24'h8040C0, 77, 32'h0000F81F);
    send_pixel(1, 2, 24'h0000FF, 180, 32'hFFFF07E0);
    drain();

    apply_setting(1, FMT_INDEXED, 1, 100, 100);
    send_pixel(50, 50, 24'hABCDEF, 255, 32'h01020304);
    send_pixel(50, 50, 24'hABCDEF, 200, 32'h01020304);
    drain();

    apply_setting(1, FMT_RGB565, 1, 100, 100);
    send_pixel(99, 99, 24'hF0E0D0, 255, 32'h55667788);
    send_pixel(0, 0, 24'hF0E0D0, 50, 32'h55667788);
    drain();

    apply_setting(1, FMT_RGBX8888, 0, 300, 200);
    send_pixel(7, 7, 24'h7F7F7F, 255, 32'hFFFFFFFF);
    send_pixel(7, 7, 24'h7F7F7F, 9, 32'hABCD1234);
    drain();

    apply_setting(0, FMT_INDEXED, 1, 0, 8192);
    send_pixel(0, 0, 24'hFFFFFF, 255, 32'hCAFEF00D);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(($urandom_range(0, 9) != 0) ? 1 : 0, $urandom_range(0, 3),
                    $urandom_range(0, 1), pick_dim(), pick_dim());
      random_pixels(ITEMS_PER_PHASE);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d pixel requests under %0d register settings, all formats and widths",
             blend_check.n_accepted, n_settings);
    $display("Results: %0d written back, %0d suppressed, %0d mismatches",
             blend_check.n_written, blend_check.n_checked - blend_check.n_written,
             blend_check.n_errors);
    if (blend_check.n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[alpha_blend_pixel_formats_top.f]
design/abpf_pkg.sv
design/abpf_cfg.sv
design/abpf_blend.sv
design/alpha_blend_pixel_formats_top.sv
design/abpf_checker.sv
dv/alpha_blend_pixel_formats_top_test.sv
